FILE: rtl/core/pmmu_pkg.sv
// shared types and constants for the paged mmu core
// no dependencies
package pmmu_pkg;
	localparam int PAGE_BYTES = 256;
	localparam int PAGES_PER_TABLE = 16;
	localparam int TABLE_COUNT = 4;
	localparam int BLOCK_COUNT = 32;
	localparam int TOTAL_PAGES = TABLE_COUNT * PAGES_PER_TABLE;
	localparam int PART_PAGES = (TABLE_COUNT / 2) * PAGES_PER_TABLE;
	localparam int PROGRAM_BYTES = PART_PAGES * PAGE_BYTES;
	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int PAGE_W = $clog2(TOTAL_PAGES);
	localparam int PART_W = $clog2(PART_PAGES);
	localparam int BLK_W = $clog2(BLOCK_COUNT);

	localparam logic [1:0] RK_PAGE_OUT = 2'd0;
	localparam logic [1:0] RK_PAGE_IN  = 2'd1;
	localparam logic [1:0] RK_ACCESS   = 2'd2;
	localparam logic [1:0] RK_LOAD_ACK = 2'd3;

	localparam logic [1:0] AK_READ  = 2'd0;
	localparam logic [1:0] AK_WRITE = 2'd1;
	localparam logic [1:0] AK_EXEC  = 2'd2;
	localparam logic [1:0] AK_INV   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OOB      = 3'd1;
	localparam logic [2:0] ST_RDENY    = 3'd2;
	localparam logic [2:0] ST_WDENY    = 3'd3;
	localparam logic [2:0] ST_XDENY    = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;
	localparam logic [2:0] ST_NOVICTIM = 3'd6;

	typedef struct packed {
		logic        action;
		logic        program_id;
		logic [15:0] virtual_address;
		logic [1:0]  access_kind;
		logic [7:0]  write_value;
		logic [2:0]  protection_bits;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [4:0]  frame_number;
		logic [5:0]  backing_page;
		logic [12:0] physical_address;
		logic [1:0]  granted_kind;
		logic [7:0]  data_out;
		logic [2:0]  status;
		logic        last;
	} rsp_t;

	// scan unit control
	typedef struct packed {
		logic             start;
		logic             prog;
	} scan_cmd_t;

	typedef struct packed {
		logic             done;
		logic             blk_found;
		logic [BLK_W-1:0] blk;
		logic             have;
		logic [PAGE_W-1:0] best;
	} scan_rsp_t;
endpackage

FILE: rtl/core/pmmu_scan.sv
// sequential scan unit: free block search, then lru victim search
// depends on pmmu_pkg
module pmmu_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pmmu_pkg::scan_cmd_t           cmd,
	input  logic [pmmu_pkg::BLOCK_COUNT-1:0] busy,
	input  logic [pmmu_pkg::TOTAL_PAGES-1:0] resident,
	input  logic [31:0]                   use_rd,
	output logic [pmmu_pkg::PAGE_W-1:0]   use_addr,
	output pmmu_pkg::scan_rsp_t           rsp
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_BLK  = 3'b010,
		S_PG   = 3'b100
	} sstate_t;

	sstate_t                       state_q;
	logic [pmmu_pkg::BLK_W:0]      bcnt_q;
	logic [pmmu_pkg::PART_W:0]     pcnt_q;
	logic                          prog_q;
	logic                          have_q;
	logic [31:0]                   bt_q;
	logic [pmmu_pkg::PAGE_W-1:0]   best_q;
	logic [pmmu_pkg::PAGE_W-1:0]   cur_pg;
	logic [pmmu_pkg::PAGE_W-1:0]   prev_pg;
	logic                          rd_valid_q;

	assign cur_pg = pmmu_pkg::PAGE_W'(prog_q) * pmmu_pkg::PAGE_W'(pmmu_pkg::PART_PAGES)
		+ pmmu_pkg::PAGE_W'(pcnt_q);
	assign prev_pg = cur_pg - 1'b1;
	assign use_addr = cur_pg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bcnt_q <= '0;
			pcnt_q <= '0;
			prog_q <= 1'b0;
			have_q <= 1'b0;
			rd_valid_q <= 1'b0;
			rsp <= '0;
			bt_q <= '0;
			best_q <= '0;
		end else begin
			rsp.done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_BLK;
						bcnt_q <= '0;
						prog_q <= cmd.prog;
					end
				end
				S_BLK: begin
					if (!busy[bcnt_q[pmmu_pkg::BLK_W-1:0]]) begin
						rsp.done <= 1'b1;
						rsp.blk_found <= 1'b1;
						rsp.blk <= bcnt_q[pmmu_pkg::BLK_W-1:0];
						state_q <= S_IDLE;
					end else if (bcnt_q == (pmmu_pkg::BLK_W+1)'(pmmu_pkg::BLOCK_COUNT - 1)) begin
						state_q <= S_PG;
						pcnt_q <= '0;
						have_q <= 1'b0;
						rd_valid_q <= 1'b0;
					end else begin
						bcnt_q <= bcnt_q + 1'b1;
					end
				end
				S_PG: begin
					// memory read of use time is registered, so it belongs to the previous counter value
					if (rd_valid_q && resident[prev_pg] && (!have_q || use_rd < bt_q)) begin
						have_q <= 1'b1;
						bt_q <= use_rd;
						best_q <= prev_pg;
					end
					if (pcnt_q == (pmmu_pkg::PART_W+1)'(pmmu_pkg::PART_PAGES)) begin
						state_q <= S_IDLE;
						rsp.done <= 1'b1;
						rsp.blk_found <= 1'b0;
						rsp.have <= have_q
							|| (rd_valid_q && resident[prev_pg]);
						rsp.best <= (rd_valid_q && resident[prev_pg]
							&& (!have_q || use_rd < bt_q)) ? prev_pg : best_q;
					end else begin
						pcnt_q <= pcnt_q + 1'b1;
						rd_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("scan state not one-hot");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_IDLE)
		else $error("scan done outside idle");
	a_pcnt: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= (pmmu_pkg::PART_W+1)'(pmmu_pkg::PART_PAGES))
		else $error("page counter overrun");
endmodule

FILE: rtl/core/paged_mmu_with_lru_replacement_core.sv
// paged mmu top level: page table state, use-time memory and sequencer
// depends on pmmu_pkg and pmmu_scan
// a load or out-of-range item is answered from decode, a hit from the access state; a miss
// searches the blocks (one a cycle) and, if none is free, the partition's pages (one a cycle)
// one item at a time: busy is high from start until the last result strobe
// results come one per cycle on done and cannot be stalled
// asynchronous reset empties the page table, frees all blocks, clears rights and time
module paged_mmu_with_lru_replacement_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pmmu_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output pmmu_pkg::rsp_t  rsp
);
	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_DEC   = 7'b0000010,
		M_SCAN  = 7'b0000100,
		M_WAIT  = 7'b0001000,
		M_POUT  = 7'b0010000,
		M_PIN   = 7'b0100000,
		M_ACC   = 7'b1000000
	} mstate_t;

	localparam int PW = pmmu_pkg::PAGE_W;
	localparam int BW = pmmu_pkg::BLK_W;

	mstate_t                           state_q;
	pmmu_pkg::req_t                    req_q;
	logic [31:0]                       time_q;
	logic [pmmu_pkg::TOTAL_PAGES-1:0]  resident_q;
	logic [pmmu_pkg::TOTAL_PAGES-1:0]  dirty_q;
	logic [pmmu_pkg::TOTAL_PAGES-1:0]  useval_q;
	logic [pmmu_pkg::TOTAL_PAGES-1:0]  protval_q;
	logic [pmmu_pkg::BLOCK_COUNT-1:0]  busy_blk_q;
	logic [2:0]                        prot_q [pmmu_pkg::TOTAL_PAGES];
	logic [BW-1:0]                     entry_q [pmmu_pkg::TOTAL_PAGES];
	logic [31:0]                       use_mem [pmmu_pkg::TOTAL_PAGES];
	logic [31:0]                       use_rd_q;
	logic [PW-1:0]                     page_q;
	logic [BW-1:0]                     blk_q;
	logic [PW-1:0]                     victim_q;
	logic [BW-1:0]                     ent_rd_q;
	logic [2:0]                        pbits_q;
	logic                              pv_rd_q;

	logic                              oob;
	logic [PW-1:0]                     page_c;
	logic [PW-1:0]                     ent_ra;
	logic [PW-1:0]                     use_addr;
	logic [31:0]                       use_rd;
	logic                              use_we;
	logic [PW-1:0]                     use_wa;
	logic [31:0]                       use_wd;
	pmmu_pkg::scan_cmd_t               scmd;
	pmmu_pkg::scan_rsp_t               srsp;
	logic [2:0]                        acc_status;
	logic [2:0]                        pbits;

	assign busy = (state_q != M_IDLE);
	assign oob = req_q.virtual_address >= 16'(pmmu_pkg::PROGRAM_BYTES);
	assign page_c = PW'(({16'd0, req_q.program_id} * 17'(pmmu_pkg::PROGRAM_BYTES)
		+ 17'(req_q.virtual_address)) >> pmmu_pkg::OFF_W);
	assign pbits = pv_rd_q ? pbits_q : 3'd0;
	assign ent_ra = (state_q == M_WAIT) ? srsp.best : page_c;

	always_comb begin
		case (req_q.access_kind)
			pmmu_pkg::AK_READ:  acc_status = pbits[0] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_RDENY;
			pmmu_pkg::AK_WRITE: acc_status = pbits[1] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_WDENY;
			pmmu_pkg::AK_EXEC:  acc_status = pbits[2] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_XDENY;
			default:            acc_status = pmmu_pkg::ST_INVALID;
		endcase
	end

	assign scmd.start = (state_q == M_DEC) && !oob && !req_q.action && !resident_q[page_c];
	assign scmd.prog = req_q.program_id;

	pmmu_scan u_scan (
		.clk(clk), .arst_n(arst_n), .cmd(scmd), .busy(busy_blk_q),
		.resident(resident_q), .use_rd(use_rd), .use_addr(use_addr), .rsp(srsp)
	);

	// use-time memory; an unwritten entry reads as zero through its valid bit
	always_ff @(posedge clk) begin
		if (use_we) use_mem[use_wa] <= use_wd;
		use_rd_q <= use_mem[use_addr];
	end
	logic uv_rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_rd_q <= 1'b0;
			pv_rd_q <= 1'b0;
		end else begin
			uv_rd_q <= useval_q[use_addr];
			pv_rd_q <= protval_q[page_c];
		end
	end
	assign use_rd = uv_rd_q ? use_rd_q : 32'd0;

	always_comb begin
		use_we = 1'b0;
		use_wa = page_q;
		use_wd = time_q;
		if (state_q == M_PIN) begin
			use_we = 1'b1;
		end else if (state_q == M_ACC && req_q.access_kind != pmmu_pkg::AK_INV) begin
			use_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) req_q <= req;
		if (state_q == M_DEC) page_q <= page_c;
		if (state_q == M_DEC && !oob && req_q.action) prot_q[page_c] <= req_q.protection_bits;
		if (state_q == M_PIN) entry_q[page_q] <= blk_q;
		if (state_q == M_WAIT && srsp.done) begin
			if (srsp.blk_found) blk_q <= srsp.blk;
			victim_q <= srsp.best;
		end
		if (state_q == M_POUT) blk_q <= ent_rd_q;
		// new entry passes straight through on page-in
		if (state_q == M_PIN) ent_rd_q <= blk_q;
		else ent_rd_q <= entry_q[ent_ra];
		pbits_q <= prot_q[page_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			time_q <= '0;
			resident_q <= '0;
			dirty_q <= '0;
			useval_q <= '0;
			protval_q <= '0;
			busy_blk_q <= '0;
			done <= 1'b0;
			rsp <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_DEC;
						time_q <= time_q + 32'd1;
					end
				end
				M_DEC: begin
					if (oob) begin
						done <= 1'b1;
						rsp <= '0;
						rsp.result_kind <= req_q.action ? pmmu_pkg::RK_LOAD_ACK
							: pmmu_pkg::RK_ACCESS;
						rsp.granted_kind <= req_q.action ? 2'd0 : req_q.access_kind;
						rsp.status <= pmmu_pkg::ST_OOB;
						rsp.last <= 1'b1;
						state_q <= M_IDLE;
					end else if (req_q.action) begin
						done <= 1'b1;
						rsp <= '0;
						rsp.result_kind <= pmmu_pkg::RK_LOAD_ACK;
						rsp.backing_page <= 6'(page_c);
						rsp.last <= 1'b1;
						protval_q[page_c] <= 1'b1;
						state_q <= M_IDLE;
					end else if (resident_q[page_c]) begin
						state_q <= M_ACC;
					end else begin
						state_q <= M_SCAN;
					end
				end
				M_SCAN: state_q <= M_WAIT;
				M_WAIT: begin
					if (srsp.done) begin
						if (srsp.blk_found) begin
							busy_blk_q[srsp.blk] <= 1'b1;
							state_q <= M_PIN;
						end else if (!srsp.have) begin
							done <= 1'b1;
							rsp <= '0;
							rsp.result_kind <= pmmu_pkg::RK_ACCESS;
							rsp.backing_page <= 6'(page_q);
							rsp.granted_kind <= req_q.access_kind;
							rsp.status <= pmmu_pkg::ST_NOVICTIM;
							rsp.last <= 1'b1;
							state_q <= M_IDLE;
						end else begin
							state_q <= M_POUT;
						end
					end
				end
				M_POUT: begin
					if (dirty_q[victim_q]) begin
						done <= 1'b1;
						rsp <= '0;
						rsp.result_kind <= pmmu_pkg::RK_PAGE_OUT;
						rsp.frame_number <= 5'(ent_rd_q);
						rsp.backing_page <= 6'(victim_q);
					end
					resident_q[victim_q] <= 1'b0;
					dirty_q[victim_q] <= 1'b0;
					useval_q[victim_q] <= 1'b0;
					state_q <= M_PIN;
				end
				M_PIN: begin
					done <= 1'b1;
					rsp <= '0;
					rsp.result_kind <= pmmu_pkg::RK_PAGE_IN;
					rsp.frame_number <= 5'(blk_q);
					rsp.backing_page <= 6'(page_q);
					resident_q[page_q] <= 1'b1;
					dirty_q[page_q] <= 1'b0;
					useval_q[page_q] <= 1'b1;
					state_q <= M_ACC;
				end
				M_ACC: begin
					done <= 1'b1;
					rsp <= '0;
					rsp.result_kind <= pmmu_pkg::RK_ACCESS;
					rsp.frame_number <= 5'(ent_rd_q);
					rsp.backing_page <= 6'(page_q);
					rsp.physical_address <= 13'({ent_rd_q,
						pmmu_pkg::OFF_W'(req_q.virtual_address)});
					rsp.granted_kind <= req_q.access_kind;
					rsp.status <= acc_status;
					if (req_q.access_kind == pmmu_pkg::AK_WRITE
						&& acc_status == pmmu_pkg::ST_OK) begin
						rsp.data_out <= req_q.write_value;
						dirty_q[page_q] <= 1'b1;
					end
					if (req_q.access_kind != pmmu_pkg::AK_INV) useval_q[page_q] <= 1'b1;
					rsp.last <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("main state not one-hot");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.last) |-> state_q == M_IDLE)
		else $error("last result while still working");
	a_pin_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_PIN |=> resident_q[page_q])
		else $error("page not resident after page-in");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_IDLE && !start) |=> !done || $past(state_q) == M_IDLE && !done)
		else $error("result while idle");
endmodule

FILE: dv/tb.sv
// testbench for the paged mmu core: random and directed accesses and loads
// checks every result strobe against an in-bench page table predictor
// depends on pmmu_pkg and paged_mmu_with_lru_replacement_core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic start;
	pmmu_pkg::req_t req;
	logic busy;
	logic done;
	pmmu_pkg::rsp_t rsp;

	paged_mmu_with_lru_replacement_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// predictor state
	logic         pt_res [pmmu_pkg::TOTAL_PAGES];
	logic [4:0]   pt_blk [pmmu_pkg::TOTAL_PAGES];
	logic         pt_dirty [pmmu_pkg::TOTAL_PAGES];
	logic [31:0]  pt_used [pmmu_pkg::TOTAL_PAGES];
	logic [2:0]   pt_prot [pmmu_pkg::TOTAL_PAGES];
	logic         blk_taken [pmmu_pkg::BLOCK_COUNT];
	logic [31:0]  tick;

	pmmu_pkg::req_t pending_items[$];
	pmmu_pkg::rsp_t expected_rsps[$];
	int errors;
	int n_sent;
	int n_checked;
	int n_pageout;
	int n_novictim;
	int cycles;
	int gap_left;
	int burst_left;
	bit hold_off;
	logic busy_q;
	bit hold_off_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pmmu_pkg::rsp_t mk(logic [1:0] k, logic [4:0] f, logic [5:0] p,
			logic [12:0] a, logic [1:0] g, logic [7:0] d, logic [2:0] s);
		pmmu_pkg::rsp_t r;
		r.result_kind = k;
		r.frame_number = f;
		r.backing_page = p;
		r.physical_address = a;
		r.granted_kind = g;
		r.data_out = d;
		r.status = s;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic translate(input pmmu_pkg::req_t it);
		pmmu_pkg::rsp_t r;
		int page;
		int off;
		int blk;
		int best;
		bit found;
		bit have;
		logic [2:0] st;
		logic [7:0] d;
		tick = tick + 32'd1;
		if (it.virtual_address >= pmmu_pkg::PROGRAM_BYTES) begin
			if (it.action)
				r = mk(pmmu_pkg::RK_LOAD_ACK, '0, '0, '0, '0, '0, pmmu_pkg::ST_OOB);
			else
				r = mk(pmmu_pkg::RK_ACCESS, '0, '0, '0, it.access_kind, '0,
					pmmu_pkg::ST_OOB);
			r.last = 1'b1;
			expected_rsps.push_back(r);
			return;
		end
		page = (it.program_id * pmmu_pkg::PROGRAM_BYTES + it.virtual_address)
			/ pmmu_pkg::PAGE_BYTES;
		off = it.virtual_address % pmmu_pkg::PAGE_BYTES;
		if (it.action) begin
			pt_prot[page] = it.protection_bits;
			r = mk(pmmu_pkg::RK_LOAD_ACK, '0, 6'(page), '0, '0, '0, pmmu_pkg::ST_OK);
			r.last = 1'b1;
			expected_rsps.push_back(r);
			return;
		end
		if (!pt_res[page]) begin
			found = 0;
			blk = 0;
			for (int b = 0; b < pmmu_pkg::BLOCK_COUNT; b++)
				if (!found && !blk_taken[b]) begin
					found = 1;
					blk = b;
				end
			if (found) begin
				blk_taken[blk] = 1'b1;
			end else begin
				have = 0;
				best = 0;
				for (int p = it.program_id * pmmu_pkg::PART_PAGES;
						p < (it.program_id + 1) * pmmu_pkg::PART_PAGES; p++)
					if (pt_res[p] && (!have || pt_used[p] < pt_used[best])) begin
						have = 1;
						best = p;
					end
				if (!have) begin
					r = mk(pmmu_pkg::RK_ACCESS, '0, 6'(page), '0, it.access_kind, '0,
						pmmu_pkg::ST_NOVICTIM);
					r.last = 1'b1;
					expected_rsps.push_back(r);
					n_novictim++;
					return;
				end
				blk = pt_blk[best];
				if (pt_dirty[best]) begin
					expected_rsps.push_back(mk(pmmu_pkg::RK_PAGE_OUT, 5'(blk), 6'(best),
						'0, '0, '0, pmmu_pkg::ST_OK));
					n_pageout++;
				end
				pt_res[best] = 1'b0;
				pt_dirty[best] = 1'b0;
				pt_used[best] = '0;
			end
			expected_rsps.push_back(mk(pmmu_pkg::RK_PAGE_IN, 5'(blk), 6'(page),
				'0, '0, '0, pmmu_pkg::ST_OK));
			pt_blk[page] = 5'(blk);
			pt_res[page] = 1'b1;
			pt_dirty[page] = 1'b0;
			pt_used[page] = tick;
		end
		d = '0;
		if (it.access_kind == pmmu_pkg::AK_INV) begin
			st = pmmu_pkg::ST_INVALID;
		end else begin
			pt_used[page] = tick;
			case (it.access_kind)
				pmmu_pkg::AK_READ: st = pt_prot[page][0] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_RDENY;
				pmmu_pkg::AK_WRITE: st = pt_prot[page][1] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_WDENY;
				default: st = pt_prot[page][2] ? pmmu_pkg::ST_OK : pmmu_pkg::ST_XDENY;
			endcase
			if (it.access_kind == pmmu_pkg::AK_WRITE && st == pmmu_pkg::ST_OK) begin
				pt_dirty[page] = 1'b1;
				d = it.write_value;
			end
		end
		r = mk(pmmu_pkg::RK_ACCESS, pt_blk[page], 6'(page),
			13'(pt_blk[page] * pmmu_pkg::PAGE_BYTES + off), it.access_kind, d, st);
		r.last = 1'b1;
		expected_rsps.push_back(r);
	endtask

	function automatic pmmu_pkg::req_t mk_req(logic a, logic pid, logic [15:0] va,
			logic [1:0] k, logic [7:0] w, logic [2:0] pb);
		pmmu_pkg::req_t it;
		it.action = a;
		it.program_id = pid;
		it.virtual_address = va;
		it.access_kind = k;
		it.write_value = w;
		it.protection_bits = pb;
		return it;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_q) begin
				translate(req);
				n_sent++;
				burst_left--;
			end
			if (start && busy_q) begin
			end else if (hold_off && expected_rsps.size() != 0 && !(start && !busy_q)) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				if (pending_items.size() == 110 && !hold_off_done) begin
					hold_off = 1;
					hold_off_done = 1;
				end
				if (hold_off && expected_rsps.size() == 0)
					hold_off = 0;
				if (!hold_off) begin
					req <= pending_items.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// item acceptance seen at the rising edge
	always @(posedge clk) busy_q <= busy;

	// monitor
	always @(posedge clk) begin
		pmmu_pkg::rsp_t e;
		cycles++;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				n_checked++;
				if (rsp !== e) begin
					$display("%0t: mismatch expected %p actual %p", $realtime, e, rsp);
					errors++;
				end
			end
		end
	end

	initial begin
		int pid;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		errors = 0;
		tick = '0;
		gap_left = 0;
		burst_left = 0;
		hold_off = 0;
		hold_off_done = 0;
		for (int i = 0; i < pmmu_pkg::TOTAL_PAGES; i++) begin
			pt_res[i] = 0; pt_blk[i] = 0; pt_dirty[i] = 0; pt_used[i] = 0; pt_prot[i] = 0;
		end
		for (int b = 0; b < pmmu_pkg::BLOCK_COUNT; b++) blk_taken[b] = 0;
		// directed items
		pending_items.push_back(mk_req(0, 0, 16'h0000, pmmu_pkg::AK_READ, 8'h00, 3'd0));
		pending_items.push_back(mk_req(1, 0, 16'h0000, pmmu_pkg::AK_READ, 8'h00, 3'd7));
		pending_items.push_back(mk_req(0, 0, 16'h00ff, pmmu_pkg::AK_WRITE, 8'hff, 3'd0));
		pending_items.push_back(mk_req(0, 0, 16'h0010, pmmu_pkg::AK_EXEC, 8'h00, 3'd0));
		pending_items.push_back(mk_req(0, 1, 16'h1fff, pmmu_pkg::AK_INV, 8'h5a, 3'd0));
		pending_items.push_back(mk_req(0, 1, 16'h2000, pmmu_pkg::AK_WRITE, 8'h11, 3'd0));
		pending_items.push_back(mk_req(1, 1, 16'hffff, pmmu_pkg::AK_INV, 8'h00, 3'd7));
		pending_items.push_back(mk_req(0, 1, 16'h1f00, pmmu_pkg::AK_READ, 8'h00, 3'd0));
		pending_items.push_back(mk_req(1, 1, 16'h1f00, pmmu_pkg::AK_READ, 8'h00, 3'd2));
		pending_items.push_back(mk_req(0, 1, 16'h1f00, pmmu_pkg::AK_WRITE, 8'haa, 3'd0));
		pending_items.push_back(mk_req(0, 1, 16'h1f00, pmmu_pkg::AK_READ, 8'h00, 3'd0));
		pending_items.push_back(mk_req(0, 1, 16'h1f00, pmmu_pkg::AK_EXEC, 8'h00, 3'd0));
		// rights on a few program 0 pages, then most blocks taken by program 0
		for (int p = 0; p < 32; p++)
			pending_items.push_back(mk_req(p < 4, 0, 16'(p * 256), pmmu_pkg::AK_WRITE,
				8'(p), 3'd7));
		// random items, mostly in range
		for (int i = 0; i < 176; i++) begin
			pid = $urandom_range(0, 1);
			pending_items.push_back(mk_req($urandom_range(0, 5) == 0, 1'(pid),
				($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191)),
				2'($urandom), 8'($urandom), 3'($urandom)));
		end
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_items.size() != 0 || start || expected_rsps.size() != 0) begin
			@(posedge clk);
			if (cycles > 400000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
		repeat (80) @(posedge clk);
		$display("run covered %0d items and %0d results, %0d page-outs, %0d no-victim misses",
			n_sent, n_checked, n_pageout, n_novictim);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
